[src/wsffa_pkg.sv]
// Shared types and constants for the weekly slot first-fit allocator.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
package wsffa_pkg;

  localparam int DAY_W   = 3;
  localparam int SLOT_W  = 7;
  localparam int MIN_W   = 11;
  localparam int LEN_W   = 8;
  localparam int LOAD_W  = 7;

  localparam logic [DAY_W-1:0]  ANY_DAY      = 3'd7;
  localparam logic [SLOT_W-1:0] START_RESET  = 7'd32;
  localparam logic [MIN_W:0]    SLOT_ROUND   = 12'd14;
  // floor(x / 15) == (x * 4370) >> 16 for every x below 2062
  localparam logic [12:0]       RECIP_15     = 13'd4370;
  localparam logic [LOAD_W-1:0] LOAD_MAX     = 7'd127;
  localparam logic [LEN_W-1:0]  LEN_MAX      = 8'd127;
  localparam logic              ST_PLACED    = 1'b0;
  localparam logic              ST_CONFLICT  = 1'b1;

  typedef struct packed {
    logic [DAY_W-1:0]  requested_day;
    logic [SLOT_W-1:0] requested_start;
    logic [MIN_W-1:0]  duration_minutes;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [DAY_W-1:0]  placed_day;
    logic [SLOT_W-1:0] placed_start;
    logic [SLOT_W-1:0] length_slots;
  } res_t;

  typedef struct packed {
    logic             load;
    logic             sort_pass;
    logic             parity;
    logic             calc_win;
    logic             commit;
    logic             finish;
    logic             ok;
    logic [DAY_W-1:0] day_idx;
  } cmd_t;

  typedef struct packed {
    logic req_bad;
    logic any_day;
    logic found;
  } stat_t;

endpackage

[src/wsffa_ctrl.sv]
// Sequencer for the allocator: sort passes, per-day scan and pick, result strobe.
// Depends on wsffa_pkg for the command and status structs.
`timescale 1ns / 1ps
module wsffa_ctrl #(
  parameter int DAYS = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  input  wsffa_pkg::stat_t stat,
  output wsffa_pkg::cmd_t  cmd
);
  import wsffa_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_SORT, S_WIN, S_PICK} state_t;

  localparam logic [DAY_W-1:0] LAST_DAY = DAY_W'(DAYS - 1);

  state_t           state;
  logic [DAY_W-1:0] cnt;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.day_idx = cnt;
    cmd.parity  = cnt[0];
    unique case (state)
      S_IDLE: cmd.load = start;
      S_PREP: begin
        cmd.finish = stat.req_bad;
      end
      S_SORT: cmd.sort_pass = 1'b1;
      S_WIN:  cmd.calc_win = 1'b1;
      S_PICK: begin
        cmd.commit = stat.found;
        cmd.ok     = stat.found;
        cmd.finish = stat.found || !stat.any_day || (cnt == LAST_DAY);
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.finish;
      unique case (state)
        S_IDLE: if (start) state <= S_PREP;
        S_PREP: begin
          cnt <= '0;
          priority if (stat.req_bad) state <= S_IDLE;
          else if (stat.any_day && DAYS > 1) state <= S_SORT;
          else state <= S_WIN;
        end
        S_SORT: begin
          // one odd-even transposition pass per cycle, DAYS passes in all
          if (cnt == LAST_DAY) begin
            cnt   <= '0;
            state <= S_WIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_WIN:  state <= S_PICK;
        S_PICK: begin
          if (cmd.finish) begin
            state <= S_IDLE;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_WIN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/wsffa_dp.sv]
// Datapath: occupancy bitmaps, day order with loads, free-run detector, result register.
// Depends on wsffa_pkg; driven by wsffa_ctrl through cmd_t and stat_t.
`timescale 1ns / 1ps
module wsffa_dp #(
  parameter int DAYS  = 7,
  parameter int SLOTS = 96
) (
  input  logic              clk,
  input  logic              rst,
  input  wsffa_pkg::req_t   req,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata,
  input  wsffa_pkg::cmd_t   cmd,
  output wsffa_pkg::stat_t  stat,
  output wsffa_pkg::res_t   result
);
  import wsffa_pkg::*;

  localparam int DIW = (DAYS > 1) ? $clog2(DAYS) : 1;
  localparam logic [LEN_W-1:0] SLOTS_L = LEN_W'(SLOTS);

  logic [SLOTS-1:0]  occ [DAYS];
  logic [DAY_W-1:0]  ord_day [DAYS];
  logic [LOAD_W-1:0] ord_load [DAYS];
  logic [SLOT_W-1:0] day_start_slot;

  logic [DAY_W-1:0]  rday;
  logic [SLOT_W-1:0] rstart;
  logic [LEN_W-1:0]  len;
  logic [SLOTS-1:0]  win;

  logic [MIN_W:0]    mins_up;
  logic [24:0]       prod;
  logic              any_day, fixed_start;
  logic [SLOT_W-1:0] org;
  logic [DAY_W-1:0]  cur_day;
  logic [SLOTS-1:0]  row, lmask, win_next;
  logic              hi_f, lo_f, found;
  logic [SLOT_W-1:0] hi_pos, lo_pos, pos;
  logic [LOAD_W-1:0] cur_load;
  logic [LEN_W-1:0]  new_load;
  logic [DAY_W-1:0]  sd_next [DAYS];
  logic [LOAD_W-1:0] sl_next [DAYS];

  assign mins_up = {1'b0, req.duration_minutes} + SLOT_ROUND;
  assign prod    = mins_up * RECIP_15;

  assign any_day     = (rday == ANY_DAY);
  assign fixed_start = !any_day && ({1'b0, rstart} < SLOTS_L);
  assign org     = ({1'b0, day_start_slot} < SLOTS_L) ? day_start_slot : '0;
  assign cur_day = any_day ? ord_day[cmd.day_idx[DIW-1:0]] : rday;
  assign row     = occ[cur_day[DIW-1:0]];
  assign lmask   = (len >= SLOTS_L) ? '1 : ((SLOTS'(1) << len) - SLOTS'(1));

  assign stat.any_day = any_day;
  assign stat.req_bad = (len == '0) || (len > SLOTS_L) ||
                        (!any_day && ({1'b0, rday} >= 4'(DAYS)));
  assign stat.found   = found;

  // window of len free slots at each start, confined to its segment
  always_comb begin
    logic [LEN_W:0] lim;
    logic           free;
    for (int s = 0; s < SLOTS; s++) begin
      free = ((row >> s) & lmask) == '0;
      lim  = (8'(s) >= {1'b0, org}) ? 9'(SLOTS) : {2'b00, org};
      if (fixed_start) begin
        win_next[s] = free && ((9'(s) + 9'(len)) <= 9'(SLOTS)) &&
                      (7'(s) == rstart);
      end else begin
        win_next[s] = free && ((9'(s) + 9'(len)) <= lim);
      end
    end
  end

  // first fit from the origin to the end of the day, then from slot zero
  always_comb begin
    hi_f = 1'b0; lo_f = 1'b0; hi_pos = '0; lo_pos = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (win[s]) begin
        if (8'(s) >= {1'b0, org}) begin
          hi_f = 1'b1; hi_pos = 7'(s);
        end else begin
          lo_f = 1'b1; lo_pos = 7'(s);
        end
      end
    end
    found = hi_f || lo_f;
    pos   = hi_f ? hi_pos : lo_pos;
  end

  always_comb begin
    cur_load = '0;
    for (int i = 0; i < DAYS; i++)
      if (ord_day[i] == cur_day) cur_load = cur_load | ord_load[i];
    new_load = {1'b0, cur_load} + len;
    if (new_load > LEN_W'(LOAD_MAX)) new_load = LEN_W'(LOAD_MAX);
  end

  // one odd-even pass; strict compare keeps equal loads in place
  always_comb begin
    for (int i = 0; i < DAYS; i++) begin
      sd_next[i] = ord_day[i];
      sl_next[i] = ord_load[i];
    end
    for (int i = 0; i + 1 < DAYS; i++) begin
      if ((i % 2) == int'(cmd.parity) && ord_load[i] > ord_load[i+1]) begin
        sd_next[i]   = ord_day[i+1];
        sl_next[i]   = ord_load[i+1];
        sd_next[i+1] = ord_day[i];
        sl_next[i+1] = ord_load[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      day_start_slot <= START_RESET;
      for (int i = 0; i < DAYS; i++) begin
        occ[i]      <= '0;
        ord_day[i]  <= DAY_W'(i);
        ord_load[i] <= '0;
      end
    end else begin
      if (cfg_we) day_start_slot <= cfg_wdata;
      if (cmd.sort_pass) begin
        for (int i = 0; i < DAYS; i++) begin
          ord_day[i]  <= sd_next[i];
          ord_load[i] <= sl_next[i];
        end
      end
      if (cmd.commit) begin
        occ[cur_day[DIW-1:0]] <= row | (lmask << pos);
        for (int i = 0; i < DAYS; i++)
          if (ord_day[i] == cur_day) ord_load[i] <= new_load[LOAD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rday   <= req.requested_day;
      rstart <= req.requested_start;
      len    <= prod[16 +: LEN_W];
    end
    if (cmd.calc_win) win <= win_next;
    if (cmd.finish) begin
      result.status       <= cmd.ok ? ST_PLACED : ST_CONFLICT;
      result.placed_day   <= cmd.ok ? cur_day : '0;
      result.placed_start <= cmd.ok ? pos : '0;
      result.length_slots <= (len > LEN_MAX) ? LEN_MAX[SLOT_W-1:0] : len[SLOT_W-1:0];
    end
  end

endmodule

[src/weekly_slot_first_fit_allocator.sv]
// Top level of the weekly slot first-fit allocator.
// Joins wsffa_ctrl and wsffa_dp; types from wsffa_pkg.
//
// Usage:
//   Request channel: drive req and raise start; the transaction is taken at a
//   rising edge with start high and busy low. busy stays high until the
//   result is produced.
//   Result channel: done is high for exactly one cycle with result valid.
//   The receiver cannot stall; the result register holds until the next one.
//   Configuration: cfg_we with cfg_wdata writes day_start_slot at once.
// Sequence after the accept edge, by wsffa_ctrl state:
//   invalid request (zero length, too long, bad day): rejected in S_PREP.
//   fixed day: S_PREP, then one scan and one pick of the day bitmap.
//   any day: S_PREP, then DAYS sort passes (S_SORT), one transposition pass
//   a cycle, then a window detect (S_WIN) and a first-fit pick (S_PICK) for
//   each of k days tried (1..DAYS).
//   A new request may be taken in the done cycle.
// Reset: all slots free, loads zero, day order identity, day_start_slot 32.
`timescale 1ns / 1ps
module weekly_slot_first_fit_allocator #(
  parameter int DAYS  = 7,
  parameter int SLOTS = 96
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  wsffa_pkg::req_t  req,
  output logic             done,
  output wsffa_pkg::res_t  result,
  input  logic             cfg_we,
  input  logic [6:0]       cfg_wdata
);
  import wsffa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  wsffa_ctrl #(.DAYS(DAYS)) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .stat (stat),
    .cmd  (cmd)
  );

  wsffa_dp #(.DAYS(DAYS), .SLOTS(SLOTS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .stat     (stat),
    .result   (result)
  );

endmodule

[src/wsffa_chk.sv]
// Port-level checks for the allocator, bound to the top level.
// Depends on wsffa_pkg for the result struct.
`timescale 1ns / 1ps
module wsffa_chk (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input wsffa_pkg::res_t result
);
  import wsffa_pkg::*;

  a_take_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");

  a_conflict_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_CONFLICT) |->
      (result.placed_day == '0 && result.placed_start == '0))
    else $error("conflict result carries a placement");

endmodule

bind weekly_slot_first_fit_allocator wsffa_chk u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);

[tb/tb_weekly_slot_first_fit_allocator.sv]
// Self-checking bench for weekly_slot_first_fit_allocator: directed table, then random requests.
// Predicts placements with an in-bench allocator model; depends on wsffa_pkg and the DUT top level.
`timescale 1ns / 1ps
module tb_weekly_slot_first_fit_allocator;
  import wsffa_pkg::*;

  localparam int NDAYS = 7;
  localparam int NSLOTS = 96;
  localparam int WDOG_LIMIT = 4000;
  localparam logic [SLOT_W-1:0] FREE_SEARCH = 7'd96;

  logic clk, rst, start, busy, done, cfg_we;
  req_t req;
  res_t result;
  logic [6:0] cfg_wdata;

  weekly_slot_first_fit_allocator DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // allocator shadow state
  logic [NSLOTS-1:0] week_busy [NDAYS];
  logic [6:0] week_load [NDAYS];
  logic [2:0] week_order [NDAYS];
  logic [6:0] origin_slot;

  res_t placements_due[$];
  int errors, accepted, results_seen, conflicts, idle_cycles;
  bit no_idle;

  typedef struct {
    req_t r;
    bit   known;
    res_t want;
  } row_t;
  row_t rows[$];

  task automatic report(string what, res_t got, res_t want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  function automatic bit slots_free(int d, int s, int n);
    if (s + n > NSLOTS) return 0;
    for (int i = s; i < s + n; i++) if (week_busy[d][i]) return 0;
    return 1;
  endfunction

  function automatic bit first_run(int d, int lo, int hi, int n, output int where);
    int run, first;
    run = 0; first = lo; where = 0;
    for (int s = lo; s < hi; s++) begin
      if (week_busy[d][s]) begin
        run = 0; first = s + 1;
      end else begin
        run++;
        if (run == n) begin
          where = first;
          return 1;
        end
      end
    end
    return 0;
  endfunction

  function automatic bit search_day(int d, int n, output int where);
    int org;
    org = (origin_slot < NSLOTS) ? origin_slot : 0;
    if (first_run(d, org, NSLOTS, n, where)) return 1;
    return first_run(d, 0, org, n, where);
  endfunction

  function automatic res_t place_request(req_t r);
    res_t o;
    int n, d, s, j, nl;
    bit ok;
    logic [2:0] key;
    n = (int'(r.duration_minutes) + 14) / 15;
    ok = 0; d = 0; s = 0;
    if (n >= 1 && n <= NSLOTS) begin
      if (r.requested_day == ANY_DAY) begin
        for (int i = 1; i < NDAYS; i++) begin
          key = week_order[i];
          j = i - 1;
          while (j >= 0 && week_load[week_order[j] % NDAYS] > week_load[key % NDAYS]) begin
            week_order[j+1] = week_order[j];
            j--;
          end
          week_order[j+1] = key;
        end
        for (int k = 0; k < NDAYS && !ok; k++) begin
          d = week_order[k] % NDAYS;
          ok = search_day(d, n, s);
        end
      end else if (r.requested_day < NDAYS) begin
        d = r.requested_day;
        if (r.requested_start < NSLOTS) begin
          s = r.requested_start;
          ok = slots_free(d, s, n);
        end else begin
          ok = search_day(d, n, s);
        end
      end
    end
    if (ok) begin
      for (int i = s; i < s + n; i++) week_busy[d][i] = 1'b1;
      nl = week_load[d] + n;
      week_load[d] = (nl > 127) ? 7'd127 : nl[6:0];
      o.status = ST_PLACED; o.placed_day = d[2:0]; o.placed_start = s[6:0];
    end else begin
      o.status = ST_CONFLICT; o.placed_day = '0; o.placed_start = '0;
    end
    o.length_slots = (n > 127) ? 7'd127 : n[6:0];
    return o;
  endfunction

  // result checker; done is sampled at the edge that ends its cycle
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (placements_due.size() == 0) begin
        report("unexpected result", result, '0);
      end else begin
        res_t w;
        w = placements_due.pop_front();
        if (result.status != w.status) report("status", result, w);
        else if (result.placed_day != w.placed_day) report("placed_day", result, w);
        else if (result.placed_start != w.placed_start) report("placed_start", result, w);
        else if (result.length_slots != w.length_slots) report("length_slots", result, w);
        if (w.status == ST_CONFLICT) conflicts++;
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("timeout waiting for a transaction");
      $display("*** FAILED ***");
      $finish;
    end
  end

  // start stays high from one transaction to the next unless an idle burst or a drain comes
  task automatic send_request(req_t r, bit known, res_t want);
    res_t p;
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = place_request(r);
    if (known && p != want) report("table row vs prediction", p, want);
    placements_due = {placements_due, p};
    accepted++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_origin(logic [6:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    origin_slot = v;
  endtask

  function automatic req_t mk(int d, int s, int m);
    req_t r;
    r.requested_day = d[2:0];
    r.requested_start = s[6:0];
    r.duration_minutes = m[10:0];
    return r;
  endfunction

  function automatic res_t rs(bit st, int d, int s, int n);
    res_t o;
    o.status = st; o.placed_day = d[2:0]; o.placed_start = s[6:0]; o.length_slots = n[6:0];
    return o;
  endfunction

  task automatic add_row(req_t r, bit known, res_t want);
    row_t t;
    t.r = r; t.known = known; t.want = want;
    rows = {rows, t};
  endtask

  function automatic req_t rand_req(bit well_formed);
    req_t r;
    int pick;
    if (!well_formed) begin
      r = req_t'($urandom());
      return r;
    end
    pick = $urandom_range(0, 9);
    r.requested_day = (pick < 4) ? ANY_DAY : 3'($urandom_range(0, 6));
    r.requested_start = ($urandom_range(0, 1)) ? FREE_SEARCH : 7'($urandom_range(0, 95));
    r.duration_minutes = ($urandom_range(0, 15) == 0) ? 11'($urandom_range(1, 1440))
                                                      : 11'($urandom_range(1, 120));
    return r;
  endfunction

  initial begin
    errors = 0; accepted = 0; results_seen = 0; conflicts = 0; no_idle = 0;
    idle_cycles = 0;
    rst = 1'b1; start = 1'b0; req = '0; cfg_we = 1'b0; cfg_wdata = '0;
    for (int d = 0; d < NDAYS; d++) begin
      week_busy[d] = '0; week_load[d] = '0; week_order[d] = d[2:0];
    end
    origin_slot = START_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; expectations given only where obvious from reset state
    add_row(mk(0, FREE_SEARCH, 0), 1, rs(ST_CONFLICT, 0, 0, 0));
    add_row(mk(0, FREE_SEARCH, 1441), 1, rs(ST_CONFLICT, 0, 0, 97));
    add_row(mk(0, FREE_SEARCH, 2047), 1, rs(ST_CONFLICT, 0, 0, 127));
    add_row(mk(0, 0, 15), 1, rs(ST_PLACED, 0, 0, 1));
    add_row(mk(1, 95, 1), 1, rs(ST_PLACED, 1, 95, 1));
    add_row(mk(1, 95, 16), 1, rs(ST_CONFLICT, 0, 0, 2));
    add_row(mk(2, FREE_SEARCH, 30), 1, rs(ST_PLACED, 2, 32, 2));
    add_row(mk(3, 0, 1440), 1, rs(ST_PLACED, 3, 0, 96));
    add_row(mk(3, FREE_SEARCH, 15), 1, rs(ST_CONFLICT, 0, 0, 1));
    add_row(mk(6, 127, 60), 1, rs(ST_PLACED, 6, 32, 4));
    add_row(mk(4, 100, 1440), 0, '0);
    add_row(mk(ANY_DAY, 10, 45), 0, '0);
    add_row(mk(ANY_DAY, FREE_SEARCH, 1440), 0, '0);
    add_row(mk(5, FREE_SEARCH, 1000), 0, '0);
    add_row(mk(5, FREE_SEARCH, 500), 0, '0);
    add_row(mk(2, 31, 16), 0, '0);
    add_row(mk(ANY_DAY, FREE_SEARCH, 14), 0, '0);
    foreach (rows[i]) send_request(rows[i].r, rows[i].known, rows[i].want);

    // origin extremes and out-of-range values, with random traffic between
    set_origin(7'd0);
    for (int i = 0; i < 60; i++) send_request(rand_req($urandom_range(0, 4) != 0), 0, '0);
    set_origin(7'd95);
    for (int i = 0; i < 60; i++) send_request(rand_req($urandom_range(0, 4) != 0), 0, '0);
    set_origin(7'd127);
    for (int i = 0; i < 60; i++) send_request(rand_req($urandom_range(0, 4) != 0), 0, '0);
    set_origin(7'd96);
    for (int i = 0; i < 60; i++) send_request(rand_req($urandom_range(0, 4) != 0), 0, '0);
    for (int p = 0; p < 3; p++) begin
      set_origin(7'($urandom()));
      for (int i = 0; i < 50; i++) send_request(rand_req($urandom_range(0, 4) != 0), 0, '0);
    end
    no_idle = 1;
    for (int i = 0; i < 60; i++) send_request(rand_req($urandom_range(0, 4) != 0), 0, '0);

    drain();
    repeat (20) @(posedge clk);
    if (placements_due.size() != 0) begin
      errors++;
      $display("%0d results never arrived", placements_due.size());
    end
    $display("requests sent %0d, results checked %0d, conflicts %0d, mismatches %0d",
             accepted, results_seen, conflicts, errors);
    $display("covered fixed, free and any-day placement under origins 0, 95, 96, 127, random");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[filelist.f]
src/wsffa_pkg.sv
src/wsffa_ctrl.sv
src/wsffa_dp.sv
src/weekly_slot_first_fit_allocator.sv
src/wsffa_chk.sv
tb/tb_weekly_slot_first_fit_allocator.sv
